// File: hw/rtl/pfe_pkg.sv
// Shared types, character constants and helpers for the Playfair encryptor.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_TEXT  = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  // ASCII bytes.
  localparam logic [7:0] CHAR_A = 8'd65;
  localparam logic [7:0] CHAR_Z = 8'd90;
  localparam logic [7:0] CHAR_I = 8'd73;
  localparam logic [7:0] CHAR_J = 8'd74;
  localparam logic [7:0] CHAR_X = 8'd88;

  // Letter indexes, A = 0.
  localparam logic [4:0] LTR_J    = 5'd9;
  localparam logic [4:0] LTR_LAST = 5'd25;

  localparam int unsigned GridN   = 5;
  localparam int unsigned Cells   = GridN * GridN;
  localparam int unsigned Letters = 26;
  localparam int unsigned QDepth  = 2;

  localparam logic [2:0] GRID_LAST = 3'(GridN - 1);
  localparam logic [2:0] GRID_END  = 3'(GridN);

  typedef enum logic {
    CMD_PLACE,
    CMD_PAIR
  } cmd_op_e;

  // For a placement, ltr_a is the letter and row/col the target cell.
  // For a pair, ltr_a and ltr_b are the two plain letters.
  typedef struct packed {
    cmd_op_e    op;
    logic [4:0] ltr_a;
    logic [4:0] ltr_b;
    logic [2:0] row;
    logic [2:0] col;
  } cmd_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CHAR_A) && (c <= CHAR_Z);
  endfunction

  function automatic logic [4:0] ltr_idx(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - CHAR_A;
    return diff[4:0];
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
    logic [4:0] sum;
    sum = {row, 2'b00} + {2'b00, row} + {2'b00, col};
    return sum;
  endfunction

  function automatic logic [2:0] inc5(input logic [2:0] x);
    return (x == GRID_LAST) ? 3'd0 : x + 3'd1;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pfe_front.sv
// Front end: accepts items, builds the key square order and text pairs, issues commands.
`timescale 1ns / 1ps
`default_nettype none

module pfe_front import pfe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] char_code_i,
  output logic            push_valid_o,
  input  wire logic       push_ready_i,
  output cmd_t            push_data_o
);

  logic [25:0] used_q, used_d;
  logic [2:0]  row_q, row_d;
  logic [2:0]  col_q, col_d;
  logic        pend_v_q, pend_v_d;
  logic [7:0]  pend_char_q, pend_char_d;
  logic        sweep_q, sweep_d;
  logic [4:0]  sweep_k_q, sweep_k_d;

  logic        full;
  logic        accept;
  logic [7:0]  char_fix;
  logic [4:0]  key_ltr;
  logic        place_req;
  logic [4:0]  place_ltr;
  logic        pair_req;
  logic [7:0]  pair_a;
  logic [7:0]  pair_b;
  logic        pair_ok;
  logic        push_fire;

  assign full       = (row_q == GRID_END);
  assign in_ready_o = !sweep_q && push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign char_fix   = (char_code_i == CHAR_J) ? CHAR_I : char_code_i;
  assign key_ltr    = ltr_idx(char_fix);
  assign pair_ok    = pair_req && is_letter(pair_a) && is_letter(pair_b);
  assign push_valid_o = place_req || pair_ok;
  assign push_fire  = push_valid_o && push_ready_i;

  always_comb begin
    used_d      = used_q;
    row_d       = row_q;
    col_d       = col_q;
    pend_v_d    = pend_v_q;
    pend_char_d = pend_char_q;
    sweep_d     = sweep_q;
    sweep_k_d   = sweep_k_q;
    place_req   = 1'b0;
    place_ltr   = key_ltr;
    pair_req    = 1'b0;
    pair_a      = pend_char_q;
    pair_b      = CHAR_X;

    if (sweep_q) begin
      // Fill pass: one alphabet letter is examined per cycle, unless a placement waits for the queue.
      place_ltr = sweep_k_q;
      place_req = (sweep_k_q != LTR_J) && !used_q[sweep_k_q] && !full;
      if (!place_req || push_ready_i) begin
        if (sweep_k_q == LTR_LAST) begin
          sweep_d = 1'b0;
        end else begin
          sweep_k_d = sweep_k_q + 5'd1;
        end
      end
    end else if (accept) begin
      unique case (kind_i)
        KIND_KEY: begin
          place_req = is_letter(char_code_i) && !full && !used_q[key_ltr];
        end
        KIND_FILL: begin
          if (!full) begin
            sweep_d   = 1'b1;
            sweep_k_d = 5'd0;
          end
        end
        KIND_TEXT: begin
          if (full) begin
            if (!pend_v_q) begin
              pend_v_d    = 1'b1;
              pend_char_d = char_fix;
            end else if (pend_char_q == char_fix) begin
              // A doubled letter is split by X and the new byte stays pending.
              pair_req = 1'b1;
            end else begin
              pend_v_d = 1'b0;
              pair_req = 1'b1;
              pair_b   = char_fix;
            end
          end
        end
        KIND_FLUSH: begin
          if (full && pend_v_q) begin
            pend_v_d = 1'b0;
            pair_req = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (place_req && push_ready_i) begin
      used_d[place_ltr] = 1'b1;
      if (col_q == GRID_LAST) begin
        col_d = 3'd0;
        row_d = row_q + 3'd1;
      end else begin
        col_d = col_q + 3'd1;
      end
    end
  end

  always_comb begin
    push_data_o.op    = place_req ? CMD_PLACE : CMD_PAIR;
    push_data_o.ltr_a = place_req ? place_ltr : ltr_idx(pair_a);
    push_data_o.ltr_b = ltr_idx(pair_b);
    push_data_o.row   = row_q;
    push_data_o.col   = col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      pend_v_q  <= 1'b0;
      sweep_q   <= 1'b0;
      sweep_k_q <= '0;
    end else begin
      used_q    <= used_d;
      row_q     <= row_d;
      col_q     <= col_d;
      pend_v_q  <= pend_v_d;
      sweep_q   <= sweep_d;
      sweep_k_q <= sweep_k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_char_q <= pend_char_d;
  end

  // Every placed letter occupies exactly one cell.
  a_fill_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(cell_addr(row_q, col_q)))
    else $error("fill position disagrees with used letter set");

  // J is never held as a pending text byte.
  a_no_pending_j: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (pend_char_q != CHAR_J))
    else $error("pending byte is J");

  // A command is only offered for a placement that is still possible.
  a_place_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    place_req |-> !full && (col_q <= GRID_LAST))
    else $error("placement beyond the square");

  // A pair can only be issued once the square is complete.
  a_pair_after_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_fire && (push_data_o.op == CMD_PAIR)) |-> full)
    else $error("pair issued before the square is complete");

endmodule

`default_nettype wire

// File: hw/rtl/pfe_queue.sv
// Two-entry command queue between the front end and the cipher engine.
`timescale 1ns / 1ps
`default_nettype none

module pfe_queue import pfe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  cmd_t      push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_fire;
  logic            pop_fire;

  assign push_ready_o = (cnt_q != CntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_fire && !pop_fire) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_fire && !push_fire) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Occupancy never exceeds the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("queue overflow");

  // Pointers are equal exactly when the queue is empty or full.
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) == ((cnt_q == '0) || (cnt_q == CntW'(QDepth))))
    else $error("queue pointers disagree with count");

  // An entry that is offered and not taken is still offered next cycle.
  a_pop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_o && !pop_ready_i) |=> pop_valid_o)
    else $error("queue entry lost");

endmodule

`default_nettype wire

// File: hw/rtl/pfe_back.sv
// Cipher engine: holds the key square and its letter position table, encrypts pairs.
`timescale 1ns / 1ps
`default_nettype none

module pfe_back import pfe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pop_valid_i,
  output logic            pop_ready_o,
  input  cmd_t            pop_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [6:0]      cipher_char_o,
  output logic            second_of_pair_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PB   = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_RA   = 3'd3;
  localparam logic [2:0] S_RB   = 3'd4;

  // Square holds a letter per cell; the position table holds {row, col} per letter.
  logic [4:0] sq_mem  [Cells];
  logic [5:0] pos_mem [Letters];

  logic [2:0] state_q, state_d;
  logic [4:0] ltr_b_q, ltr_b_d;
  logic [2:0] pa_row_q, pa_row_d;
  logic [2:0] pa_col_q, pa_col_d;
  logic [4:0] eb_addr_q, eb_addr_d;
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_char_q, out_char_d;
  logic       out_second_q, out_second_d;
  logic [4:0] sq_rd_q;
  logic [5:0] pos_rd_q;

  logic       sq_we;
  logic [4:0] sq_waddr;
  logic       sq_re;
  logic [4:0] sq_raddr;
  logic       pos_we;
  logic       pos_re;
  logic [4:0] pos_raddr;
  logic       out_load;
  logic       pop_fire;
  logic [2:0] pb_row;
  logic [2:0] pb_col;
  logic [2:0] ea_row, ea_col, eb_row, eb_col;
  logic [6:0] sq_char;

  assign out_load  = !out_valid_q || out_ready_i;
  assign pop_fire  = pop_valid_i && pop_ready_o;
  assign sq_waddr  = cell_addr(pop_data_i.row, pop_data_i.col);
  assign pb_row    = pos_rd_q[5:3];
  assign pb_col    = pos_rd_q[2:0];
  assign sq_char   = CHAR_A[6:0] + {2'b00, sq_rd_q};

  // Playfair substitution on the two cell coordinates.
  always_comb begin
    if (pa_row_q == pb_row) begin
      ea_row = pa_row_q;
      ea_col = inc5(pa_col_q);
      eb_row = pb_row;
      eb_col = inc5(pb_col);
    end else if (pa_col_q == pb_col) begin
      ea_row = inc5(pa_row_q);
      ea_col = pa_col_q;
      eb_row = inc5(pb_row);
      eb_col = pb_col;
    end else begin
      ea_row = pa_row_q;
      ea_col = pb_col;
      eb_row = pb_row;
      eb_col = pa_col_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    ltr_b_d      = ltr_b_q;
    pa_row_d     = pa_row_q;
    pa_col_d     = pa_col_q;
    eb_addr_d    = eb_addr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_char_d   = out_char_q;
    out_second_d = out_second_q;
    pop_ready_o  = 1'b0;
    sq_we        = 1'b0;
    pos_we       = 1'b0;
    sq_re        = 1'b0;
    sq_raddr     = eb_addr_q;
    pos_re       = 1'b0;
    pos_raddr    = pop_data_i.ltr_a;

    unique case (state_q)
      S_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          if (pop_data_i.op == CMD_PLACE) begin
            sq_we  = 1'b1;
            pos_we = 1'b1;
          end else begin
            ltr_b_d = pop_data_i.ltr_b;
            pos_re  = 1'b1;
            state_d = S_PB;
          end
        end
      end
      S_PB: begin
        pa_row_d  = pos_rd_q[5:3];
        pa_col_d  = pos_rd_q[2:0];
        pos_re    = 1'b1;
        pos_raddr = ltr_b_q;
        state_d   = S_CALC;
      end
      S_CALC: begin
        sq_re     = 1'b1;
        sq_raddr  = cell_addr(ea_row, ea_col);
        eb_addr_d = cell_addr(eb_row, eb_col);
        state_d   = S_RA;
      end
      S_RA: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_char_d   = sq_char;
          out_second_d = 1'b0;
          sq_re        = 1'b1;
          state_d      = S_RB;
        end
      end
      S_RB: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_char_d   = sq_char;
          out_second_d = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ltr_b_q      <= ltr_b_d;
    pa_row_q     <= pa_row_d;
    pa_col_q     <= pa_col_d;
    eb_addr_q    <= eb_addr_d;
    out_char_q   <= out_char_d;
    out_second_q <= out_second_d;
  end

  always_ff @(posedge clk_i) begin
    if (sq_we) begin
      sq_mem[sq_waddr] <= pop_data_i.ltr_a;
    end
    if (sq_re) begin
      sq_rd_q <= sq_mem[sq_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pop_data_i.ltr_a] <= {pop_data_i.row, pop_data_i.col};
    end
    if (pos_re) begin
      pos_rd_q <= pos_mem[pos_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cipher_char_o    = out_char_q;
  assign second_of_pair_o = out_second_q;

  // Placements always land inside the square.
  a_place_in_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_fire && (pop_data_i.op == CMD_PLACE)) |->
      (pop_data_i.row <= GRID_LAST) && (pop_data_i.col <= GRID_LAST))
    else $error("placement outside the square");

  // While the second letter is being fetched, the first one is still on the output.
  a_first_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RB) |-> (out_valid_q && !out_second_q))
    else $error("first cipher letter not on the output");

  // Commands are only taken between pairs.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_fire |-> (state_q == S_IDLE))
    else $error("command taken while a pair is in progress");

endmodule

`default_nettype wire

// File: hw/rtl/playfair_encryptor.sv
// Top level of the Playfair encryptor: front end, command queue and cipher engine.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   kind_i[1:0], char_code_i[7:0]
//   out      output     out_valid_o / out_ready_i cipher_char_o[6:0], second_of_pair_o
//
// A key end holds off input while the front end walks the alphabet once, one letter
// a cycle while the queue has room. In the cipher engine a pair takes two position
// table reads, then two square reads, each memory having one registered read port.
// Reset empties the queue and clears the key state; the square memories need no clear.
// Input stalls when the two-entry queue is full; output stalls back up into the queue.
`timescale 1ns / 1ps
`default_nettype none

module playfair_encryptor import pfe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] char_code_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [6:0]      cipher_char_o,
  output logic            second_of_pair_o
);

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  pfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pfe_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_data_i       (pop_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cipher_char_o    (cipher_char_o),
    .second_of_pair_o (second_of_pair_o)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the Playfair encryptor: directed table, then random items.
`timescale 1ns / 1ps

module tb;
  import pfe_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic       typed;
    logic [1:0] n_out;
    logic [7:0] c0;
    logic [7:0] c1;
  } drill_row_t;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } cipher_t;

  localparam int DrillRows = 27;
  localparam int RandomItems = 650;

  // Key ZJI (with junk bytes) gives the square
  //   Z I A B C / D E F G H / K L M N O / P Q R S T / U V W X Y
  localparam drill_row_t DRILL_TBL [DrillRows] = '{
    '{KIND_TEXT,  "A",   1'b1, 2'd0, 8'h00, 8'h00},
    '{KIND_FLUSH, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{KIND_KEY,   8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_KEY,   8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_KEY,   "a",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_KEY,   "Z",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_KEY,   "J",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_KEY,   "I",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_FILL,  8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_FILL,  8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_KEY,   "Q",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_TEXT,  "A",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_TEXT,  "B",   1'b1, 2'd2, "B",   "C"  },
    '{KIND_TEXT,  "E",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_TEXT,  "V",   1'b1, 2'd2, "L",   "I"  },
    '{KIND_TEXT,  "D",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_TEXT,  "Y",   1'b1, 2'd2, "H",   "U"  },
    '{KIND_TEXT,  "X",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_TEXT,  "Y",   1'b1, 2'd2, "Y",   "U"  },
    '{KIND_TEXT,  "L",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_TEXT,  "L",   1'b1, 2'd2, "N",   "V"  },
    '{KIND_TEXT,  "J",   1'b1, 2'd2, "Q",   "E"  },
    '{KIND_TEXT,  "A",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_TEXT,  8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_TEXT,  "X",   1'b0, 2'd0, 8'h00, 8'h00},
    '{KIND_FLUSH, 8'h00, 1'b1, 2'd2, "Y",   "Y"  },
    '{KIND_FLUSH, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] kind_i      = KIND_KEY;
  logic [7:0] char_code_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [6:0] cipher_char_o;
  logic       second_of_pair_o;

  playfair_encryptor DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .char_code_i     (char_code_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cipher_char_o   (cipher_char_o),
    .second_of_pair_o(second_of_pair_o)
  );

  always #5 clk_i = ~clk_i;

  // Predicted key square and text pairing state.
  logic [4:0]  key_sq [Cells];
  logic [25:0] ltr_placed = '0;
  int unsigned cells_filled = 0;
  logic [7:0]  held_char = 8'h00;
  logic        held_valid = 1'b0;

  cipher_t cipher_due_q [$];
  int      err_count = 0;
  bit      idle_on = 1'b1;

  function automatic void key_place(input logic [4:0] ltr);
    if (cells_filled >= Cells || ltr >= Letters) return;
    if (ltr_placed[ltr]) return;
    ltr_placed[ltr] = 1'b1;
    key_sq[cells_filled] = ltr;
    cells_filled++;
  endfunction

  function automatic int cell_of(input logic [4:0] ltr);
    for (int p = 0; p < Cells; p++) begin
      if (key_sq[p] == ltr) return p;
    end
    return 0;
  endfunction

  function automatic int cipher_pair(input logic [7:0] a, input logic [7:0] b,
                                     output logic [6:0] ltr0, output logic [6:0] ltr1);
    int pa, pb, ra, rb, cola, colb, ea, eb;
    ltr0 = '0;
    ltr1 = '0;
    if (a < CHAR_A || a > CHAR_Z || b < CHAR_A || b > CHAR_Z) return 0;
    pa = cell_of(5'(a - CHAR_A));
    pb = cell_of(5'(b - CHAR_A));
    ra = pa / GridN;
    cola = pa % GridN;
    rb = pb / GridN;
    colb = pb % GridN;
    if (ra == rb) begin
      ea = ra * GridN + (cola + 1) % GridN;
      eb = rb * GridN + (colb + 1) % GridN;
    end else if (cola == colb) begin
      ea = ((ra + 1) % GridN) * GridN + cola;
      eb = ((rb + 1) % GridN) * GridN + colb;
    end else begin
      ea = ra * GridN + colb;
      eb = rb * GridN + cola;
    end
    ltr0 = 7'(CHAR_A + key_sq[ea]);
    ltr1 = 7'(CHAR_A + key_sq[eb]);
    return 2;
  endfunction

  // Advances the predicted state by one transaction and returns the number of
  // cipher letters it produces.
  function automatic int playfair_encrypt_step(input logic [1:0] kind, input logic [7:0] code,
                                               output logic [6:0] ltr0,
                                               output logic [6:0] ltr1);
    logic [4:0] ltr;
    logic [7:0] b;
    logic [7:0] first;
    ltr0 = '0;
    ltr1 = '0;
    if (kind == KIND_KEY) begin
      if (code >= CHAR_A && code <= CHAR_Z) begin
        ltr = 5'(code - CHAR_A);
        if (ltr == LTR_J) ltr = 5'(CHAR_I - CHAR_A);
        key_place(ltr);
      end
      return 0;
    end
    if (kind == KIND_FILL) begin
      for (int k = 0; k < Letters; k++) begin
        if (k != LTR_J) key_place(5'(k));
      end
      return 0;
    end
    if (cells_filled < Cells) return 0;
    if (kind == KIND_FLUSH) begin
      if (!held_valid) return 0;
      held_valid = 1'b0;
      return cipher_pair(held_char, CHAR_X, ltr0, ltr1);
    end
    b = (code == CHAR_J) ? CHAR_I : code;
    if (!held_valid) begin
      held_char = b;
      held_valid = 1'b1;
      return 0;
    end
    first = held_char;
    // A doubled letter is split with X and the new byte stays held.
    if (first == b) return cipher_pair(first, CHAR_X, ltr0, ltr1);
    held_valid = 1'b0;
    return cipher_pair(first, b, ltr0, ltr1);
  endfunction

  // Drives one transaction from a falling edge and returns at the falling edge after
  // it is accepted, with valid still high.
  task automatic send_item(input logic [1:0] k, input logic [7:0] c, input logic typed,
                           input logic [1:0] tn, input logic [7:0] t0, input logic [7:0] t1);
    int n;
    logic [6:0] p0, p1;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    n = playfair_encrypt_step(k, c, p0, p1);
    if (typed) begin
      n = tn;
      p0 = t0[6:0];
      p1 = t1[6:0];
    end
    if (n == 2) begin
      cipher_due_q.push_back('{p0, 1'b0});
      cipher_due_q.push_back('{p1, 1'b1});
    end
    in_valid_i = 1'b1;
    kind_i = k;
    char_code_i = c;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin : ready_drive
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    cipher_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_due_q.size() == 0) begin
        $error("unexpected result: cipher_char 0x%0h second_of_pair %0b",
               cipher_char_o, second_of_pair_o);
        err_count++;
      end else begin
        due = cipher_due_q.pop_front();
        if (cipher_char_o !== due.letter) begin
          $error("cipher_char: expected 0x%0h, actual 0x%0h", due.letter, cipher_char_o);
          err_count++;
        end
        if (second_of_pair_o !== due.last) begin
          $error("second_of_pair: expected %0b, actual %0b", due.last, second_of_pair_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("playfair_encryptor verification failed");
    $finish;
  end

  initial begin : stimulus
    int counted;
    int sel;
    logic [1:0] k;
    logic [7:0] code;
    logic [7:0] last_ltr;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DrillRows; i++) begin
      send_item(DRILL_TBL[i].kind, DRILL_TBL[i].code, DRILL_TBL[i].typed,
                DRILL_TBL[i].n_out, DRILL_TBL[i].c0, DRILL_TBL[i].c1);
    end
    in_valid_i = 1'b0;
    wait (cipher_due_q.size() == 0);
    @(negedge clk_i);

    // Mostly letter text, so that pairs form often; the rest is noise, flushes, stray keys and fills.
    counted = 0;
    last_ltr = CHAR_A;
    while (counted < RandomItems) begin
      if (counted % 50 == 0) idle_on = (counted < 550) && ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      code = 8'($urandom_range(0, 255));
      if (sel < 78) begin
        k = KIND_TEXT;
        if ($urandom_range(0, 5) != 0) code = 8'(CHAR_A + $urandom_range(0, 25));
        else code = last_ltr;
        last_ltr = code;
      end else if (sel < 85) begin
        k = KIND_TEXT;
      end else if (sel < 91) begin
        k = KIND_FLUSH;
      end else if (sel < 96) begin
        k = KIND_KEY;
      end else begin
        k = KIND_FILL;
      end
      send_item(k, code, 1'b0, 2'd0, 8'h00, 8'h00);
      counted++;
      if (counted % 160 == 0) begin
        in_valid_i = 1'b0;
        wait (cipher_due_q.size() == 0);
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b0;

    wait (cipher_due_q.size() == 0);
    repeat (30) @(posedge clk_i);
    if (err_count == 0) begin
      $display("playfair_encryptor verification clean");
    end else begin
      $display("playfair_encryptor verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_front.sv
hw/rtl/pfe_queue.sv
hw/rtl/pfe_back.sv
hw/rtl/playfair_encryptor.sv
tb/tb.sv
